### rtl/core/sfs_pkg.sv
// Shared constants, types and codes for the sector fixup stream unit.
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int MAX_SECTORS     = 8;
    localparam int SECTOR_BYTES    = 512;
    localparam int SECTOR_WORDS    = SECTOR_BYTES / 2;
    localparam int ENTRY_DEPTH     = MAX_SECTORS + 1;
    localparam int RECORD_WORDS    = MAX_SECTORS * SECTOR_WORDS;

    localparam int WORD_W          = 16;
    localparam int POS_W           = 12;
    localparam int SECTOR_WORD_W   = $clog2(SECTOR_WORDS);
    localparam int SEC_W           = POS_W - SECTOR_WORD_W + 1;
    localparam int IDX_W           = $clog2(ENTRY_DEPTH);

    // Earliest byte offset that does not overlap the header words already passed.
    localparam int MIN_OFFSET      = 8;
    // First position at which array entries and check words can appear.
    localparam int FIRST_BODY_POS  = 4;
    localparam int OFFSET_POS      = 2;
    localparam int COUNT_POS       = 3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_LAYOUT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              fixed;
        logic              last;
        t_status           status;
    } t_result;

endpackage

### rtl/core/sfs_in_reg.sv
// Input register stage of the sector fixup stream unit.
`timescale 1ns / 1ps

module sfs_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sfs_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_stall,
    output logic          o_valid,
    output sfs_pkg::t_item o_item
);
    import sfs_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload until the item moves on.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/sfs_fixup_core.sv
// Record state, update sequence array store and per-word fixup logic.
`timescale 1ns / 1ps

module sfs_fixup_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  sfs_pkg::t_item  i_item,
    output sfs_pkg::t_result o_result
);
    import sfs_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [WORD_W-1:0] r_off;
    logic [WORD_W-1:0] n_off;
    logic [WORD_W-1:0] r_cnt;
    logic [WORD_W-1:0] n_cnt;
    logic              r_mismatch;
    logic              n_mismatch;
    logic              r_bad;
    logic              n_bad;
    logic [WORD_W-1:0] r_entries [ENTRY_DEPTH];

    logic              is_off_pos;
    logic              is_cnt_pos;
    logic              body;
    logic [WORD_W+1:0] array_end;
    logic              bad_hdr;
    logic              bad_now;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] k;
    logic              store;
    logic [IDX_W-1:0]  store_idx;
    logic              sec_end;
    logic [SEC_W-1:0]  sec;
    logic [IDX_W-1:0]  sec_idx;
    logic              hit;
    logic              too_long;

    assign is_off_pos = (r_pos == POS_W'(OFFSET_POS));
    assign is_cnt_pos = (r_pos == POS_W'(COUNT_POS));
    assign body       = (r_pos >= POS_W'(FIRST_BODY_POS)) && !r_bad;

    // Header check at the count word.
    assign array_end = {2'b00, r_off} + {1'b0, i_item.word, 1'b0};
    assign bad_hdr   = r_off[0]
                     || (r_off < WORD_W'(MIN_OFFSET))
                     || ((i_item.word != '0) && (array_end > (WORD_W+2)'(SECTOR_BYTES - 2)))
                     || (i_item.word > WORD_W'(ENTRY_DEPTH));
    assign bad_now   = r_bad || (is_cnt_pos && bad_hdr);

    // Capture array entries as they pass.
    assign base      = {1'b0, r_off[WORD_W-1:1]};
    assign k         = {{(WORD_W-POS_W){1'b0}}, r_pos} - base;
    assign store     = body && ({{(WORD_W-POS_W){1'b0}}, r_pos} >= base)
                     && (k < r_cnt) && (k < WORD_W'(ENTRY_DEPTH));
    assign store_idx = k[IDX_W-1:0];

    // Check word at the end of each sector.
    assign sec_end = &r_pos[SECTOR_WORD_W-1:0];
    assign sec     = {1'b0, r_pos[POS_W-1:SECTOR_WORD_W]} + SEC_W'(1);
    assign sec_idx = IDX_W'(sec);
    assign hit     = body && sec_end
                   && ({{(WORD_W-SEC_W){1'b0}}, sec} < r_cnt)
                   && (sec < SEC_W'(ENTRY_DEPTH));

    assign too_long = !i_item.last && (r_pos == POS_W'(RECORD_WORDS - 1));

    always_comb begin
        o_result.word   = hit ? r_entries[sec_idx] : i_item.word;
        o_result.fixed  = hit;
        o_result.last   = i_item.last;
        o_result.status = STATUS_OK;
        if (i_item.last) begin
            if ((r_pos < POS_W'(COUNT_POS)) || bad_now) begin
                o_result.status = STATUS_LAYOUT;
            end else if (r_mismatch || (hit && (r_entries[0] != i_item.word))) begin
                o_result.status = STATUS_MISMATCH;
            end else begin
                o_result.status = STATUS_OK;
            end
        end
    end

    always_comb begin
        if (i_item.last) begin
            n_pos      = '0;
            n_off      = '0;
            n_cnt      = '0;
            n_mismatch = 1'b0;
            n_bad      = 1'b0;
        end else begin
            n_pos      = r_pos + POS_W'(1);
            n_off      = is_off_pos ? i_item.word : r_off;
            n_cnt      = is_cnt_pos ? i_item.word : r_cnt;
            n_mismatch = r_mismatch || (hit && (r_entries[0] != i_item.word));
            n_bad      = bad_now || too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_off      <= '0;
            r_cnt      <= '0;
            r_mismatch <= 1'b0;
            r_bad      <= 1'b0;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_off      <= n_off;
            r_cnt      <= n_cnt;
            r_mismatch <= n_mismatch;
            r_bad      <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && store) begin
            r_entries[store_idx] <= i_item.word;
        end
    end

endmodule

### rtl/core/sector_fixup_stream_unit.sv
// Top level of the sector fixup stream unit: input stage, fixup core, result register.
`timescale 1ns / 1ps

// Streams a file-system record one 16-bit word per transfer and applies the
// update sequence array fixup. Header word 2 gives the array offset in bytes
// and word 3 the entry count; array entries are captured as they pass. The
// last word of each 512-byte sector that has an array entry is compared with
// entry 0 and replaced by the entry for that sector (o_out_fixed marks it);
// every other word passes unchanged. On the word marked last, o_status reports
// ok, check mismatch, or unsupported layout (odd or too small offset, array
// past the first check word, too many entries, record over MAX_SECTORS
// sectors, or a record that ends before word 3). Throughput is one word per
// clock unless the output stalls; each word passes the input register and then
// the result register, with the fixup done in a single pass between them.
// Stall on the output side backs up through both registers to o_stall.
module sector_fixup_stream_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_in_word,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_word,
    output logic        o_out_fixed,
    output logic        o_out_last,
    output logic [1:0]  o_status
);
    import sfs_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    t_result result;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    assign in_item.word = i_in_word;
    assign in_item.last = i_in_last;

    // Advance when the result register is empty or being drained.
    assign advance = stage_valid && (!r_out_valid || !i_stall);

    sfs_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_stall),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    sfs_fixup_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_result  (result)
    );

    always_comb begin
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result while stalled; load a new one on each advance.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_word  = r_out.word;
    assign o_out_fixed = r_out.fixed;
    assign o_out_last  = r_out.last;
    assign o_status    = r_out.status;

endmodule
